[rtl/tla_pkg.sv]
// ----------------------------------------------------------------------------
// tla_pkg
// Shared types and constants for the temperature limit alarm core.
// ----------------------------------------------------------------------------
package tla_pkg;

    // Event codes carried in the input tuser field
    typedef enum logic [2:0] {
        KIND_TICK   = 3'd0,
        KIND_SAMPLE = 3'd1,
        KIND_SET    = 3'd2,
        KIND_UP     = 3'd3,
        KIND_DOWN   = 3'd4,
        KIND_PAGE   = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        MODE_MONITOR = 2'd0,
        MODE_EDIT_HI = 2'd1,
        MODE_EDIT_LO = 2'd2
    } t_mode;

    localparam int KIND_W   = 3;
    localparam int RAW_W    = 16;
    localparam int LIMIT_W  = 7;
    localparam int TEMP_W   = 11;
    localparam int TICK_W   = 4;
    localparam int OUT_W    = 32;

    localparam logic [TEMP_W-1:0]  TEMP_MAX_TENTHS = 11'd1200;
    localparam logic [LIMIT_W-1:0] DEG_AT_MAX      = 7'd120;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX       = 7'd99;
    localparam logic [LIMIT_W-1:0] HIGH_RESET      = 7'd40;
    localparam logic [LIMIT_W-1:0] LOW_RESET       = 7'd10;
    localparam logic [TICK_W-1:0]  BLINK_LAST_TICK = 4'd9;

endpackage

[rtl/temperature_limit_alarm_core.sv]
// ----------------------------------------------------------------------------
// temperature_limit_alarm_core
// High/low temperature limit alarm: converts raw sensor samples to tenths of
// a degree, keeps editable limits and drives lamp, blinking buzzer and LEDs.
// ----------------------------------------------------------------------------
//  channel  dir  signals                          content
//  s        in   i_s_tvalid/o_s_tready, tdata,    one event per request
//                i_s_tuser
//  m        out  o_m_tvalid/i_m_tready, o_m_tdata one status word per event
//
//  One event per cycle while the sink accepts; events pass the input register,
//  then the result register. State is updated when an event moves from the
//  input register into the result register. The input register keeps taking a
//  request while a result waits, so one stalled result blocks the input only
//  one item later. Reset (synchronous, active low) restores limits 40/10,
//  monitor mode, keys disabled and clears the pipeline.
// ----------------------------------------------------------------------------
module temperature_limit_alarm_core
    import tla_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [15:0]       i_s_tdata,   // [15:0] raw_reading
    input  logic [2:0]        i_s_tuser,   // [2:0] kind
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_W-1:0]  o_m_tdata    // [0] buzzer_on, [1] alarm_light,
                                           // [2] over_led, [3] under_led,
                                           // [5:4] edit_mode,
                                           // [12:6] high_limit_out,
                                           // [19:13] low_limit_out,
                                           // [30:20] temp_tenths, [31] zero
);

    // input register
    logic              r_in_valid;
    logic [KIND_W-1:0] r_in_kind;
    logic [RAW_W-1:0]  r_in_raw;

    // block state
    t_mode              r_mode,  n_mode;
    logic [LIMIT_W-1:0] r_high,  n_high;
    logic [LIMIT_W-1:0] r_low,   n_low;
    logic [TEMP_W-1:0]  r_temp,  n_temp;
    logic [LIMIT_W-1:0] r_deg,   n_deg;
    logic               r_blink, n_blink;
    logic [TICK_W-1:0]  r_tick,  n_tick;
    logic               r_keys,  n_keys;
    logic               r_over,  n_over;
    logic               r_under, n_under;

    // result register
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data, n_out_data;

    logic              advance;
    logic [19:0]       scaled;
    logic [RAW_W-1:0]  conv;
    logic              conv_sat;
    logic              cond;
    logic              buzz;
    logic              lamp;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // raw*10 + 8 as two shifts and an add; tenths = that >> 4
    assign scaled   = 20'({r_in_raw, 3'b000}) + 20'({r_in_raw, 1'b0}) + 20'd8;
    assign conv     = scaled[19:4];
    assign conv_sat = conv > RAW_W'(TEMP_MAX_TENTHS);

    always_comb begin
        n_mode  = r_mode;
        n_high  = r_high;
        n_low   = r_low;
        n_temp  = r_temp;
        n_deg   = r_deg;
        n_blink = r_blink;
        n_tick  = r_tick;
        n_keys  = r_keys;
        n_over  = r_over;
        n_under = r_under;
        buzz    = 1'b0;
        lamp    = 1'b0;

        case (r_in_kind)
            KIND_TICK: begin
                if (r_tick == BLINK_LAST_TICK) begin
                    n_tick  = '0;
                    n_blink = !r_blink;
                end else begin
                    n_tick = r_tick + 1'b1;
                end
            end
            KIND_SAMPLE: begin
                // whole degrees of the rounded tenths equal raw >> 4
                n_temp = conv_sat ? TEMP_MAX_TENTHS : conv[TEMP_W-1:0];
                n_deg  = conv_sat ? DEG_AT_MAX : r_in_raw[10:4];
            end
            KIND_SET: begin
                if (r_keys) begin
                    case (r_mode)
                        MODE_MONITOR: n_mode = MODE_EDIT_HI;
                        MODE_EDIT_HI: n_mode = MODE_EDIT_LO;
                        default:      n_mode = MODE_MONITOR;
                    endcase
                end
            end
            KIND_UP: begin
                if (r_keys) begin
                    if (r_mode == MODE_EDIT_HI) begin
                        n_high = (r_high >= LIMIT_MAX) ? LIMIT_MAX : r_high + 1'b1;
                    end else if (r_mode == MODE_EDIT_LO) begin
                        n_low = (r_low + 1'b1 >= r_high) ? r_high - 1'b1 : r_low + 1'b1;
                    end
                end
            end
            KIND_DOWN: begin
                if (r_keys) begin
                    if (r_mode == MODE_EDIT_HI) begin
                        n_high = (r_high <= r_low + 1'b1) ? r_low + 1'b1 : r_high - 1'b1;
                    end else if (r_mode == MODE_EDIT_LO) begin
                        if (r_low != '0) begin
                            n_low = r_low - 1'b1;
                        end
                    end
                end
            end
            KIND_PAGE: begin
                n_keys = !r_keys;
            end
            default: begin
            end
        endcase

        cond = (n_deg >= n_high) || (n_deg < n_low);
        if (n_mode == MODE_MONITOR) begin
            lamp    = cond;
            buzz    = cond && n_blink;
            n_over  = n_deg >= n_high;
            n_under = n_deg <= n_low;
        end

        n_out_data = {1'b0, n_temp, n_low, n_high, n_mode, n_under, n_over, lamp, buzz};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_MONITOR;
            r_high      <= HIGH_RESET;
            r_low       <= LOW_RESET;
            r_temp      <= '0;
            r_deg       <= '0;
            r_blink     <= 1'b0;
            r_tick      <= '0;
            r_keys      <= 1'b0;
            r_over      <= 1'b0;
            r_under     <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
                r_high      <= n_high;
                r_low       <= n_low;
                r_temp      <= n_temp;
                r_deg       <= n_deg;
                r_blink     <= n_blink;
                r_tick      <= n_tick;
                r_keys      <= n_keys;
                r_over      <= n_over;
                r_under     <= n_under;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_kind <= i_s_tuser;
            r_in_raw  <= i_s_tdata;
        end
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    // limits stay ordered whatever keys arrive
    a_limits_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_low < r_high) && (r_high <= LIMIT_MAX))
        else $error("limit order broken");

    a_tick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tick <= BLINK_LAST_TICK)
        else $error("tick counter out of range");

    // lamp and buzzer stay dark while a limit is being edited
    a_edit_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[5:4] != MODE_MONITOR)) |-> (o_m_tdata[1:0] == 2'b00))
        else $error("alarm active in edit mode");

    a_buzz_needs_lamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |-> o_m_tdata[1])
        else $error("buzzer without alarm lamp");

endmodule

[tb/temperature_limit_alarm_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temperature_limit_alarm_core_tb
// Streams tick, sample, key and page events into the alarm core. A scoreboard
// predicts the status word for each accepted request and checks every result
// field by field, with random source gaps and sink back-pressure.
// ----------------------------------------------------------------------------
module temperature_limit_alarm_core_tb;
    import tla_pkg::*;

    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         PHASE_ITEMS  = 100;

    // status word, lowest bit last in this list
    typedef struct packed {
        logic              pad;
        logic [TEMP_W-1:0] temp_tenths;
        logic [LIMIT_W-1:0] low_limit;
        logic [LIMIT_W-1:0] high_limit;
        t_mode             mode;
        logic              under_led;
        logic              over_led;
        logic              alarm_light;
        logic              buzzer_on;
    } t_status;

    class alarm_scoreboard;
        t_mode   mode_now;
        int      high_lim;
        int      low_lim;
        int      temp_tenths;
        bit      blink;
        int      tick_cnt;
        bit      keys_on;
        bit      over_flag;
        bit      under_flag;
        int      errors;
        t_status status_q[$];

        function new();
            mode_now    = MODE_MONITOR;
            high_lim    = 40;
            low_lim     = 10;
            temp_tenths = 0;
            blink       = 1'b0;
            tick_cnt    = 0;
            keys_on     = 1'b0;
            over_flag   = 1'b0;
            under_flag  = 1'b0;
            errors      = 0;
        endfunction

        function void note_event(logic [2:0] kind, logic [15:0] raw);
            int      scaled;
            int      deg;
            bit      cond;
            t_status want;
            want = '0;
            case (kind)
                KIND_TICK: tick_cnt = (tick_cnt + 1) % 16;
                KIND_SAMPLE: begin
                    scaled = (int'(raw) * 10 + 8) >> 4;
                    temp_tenths = (scaled > 1200) ? 1200 : scaled;
                end
                KIND_SET: begin
                    if (keys_on) begin
                        case (mode_now)
                            MODE_MONITOR: mode_now = MODE_EDIT_HI;
                            MODE_EDIT_HI: mode_now = MODE_EDIT_LO;
                            default:      mode_now = MODE_MONITOR;
                        endcase
                    end
                end
                KIND_UP: begin
                    if (keys_on && mode_now == MODE_EDIT_HI) begin
                        high_lim = high_lim + 1;
                        if (high_lim >= 99) high_lim = 99;
                    end else if (keys_on && mode_now == MODE_EDIT_LO) begin
                        low_lim = low_lim + 1;
                        if (low_lim >= high_lim) low_lim = high_lim - 1;
                    end
                end
                KIND_DOWN: begin
                    if (keys_on && mode_now == MODE_EDIT_HI) begin
                        // high limit never drops onto the low limit
                        if (high_lim <= low_lim + 1) high_lim = low_lim + 1;
                        else high_lim = high_lim - 1;
                    end else if (keys_on && mode_now == MODE_EDIT_LO) begin
                        if (low_lim > 0) low_lim = low_lim - 1;
                    end
                end
                KIND_PAGE: keys_on = !keys_on;
                default: ;
            endcase
            if (tick_cnt >= 10) begin
                blink    = !blink;
                tick_cnt = 0;
            end
            if (mode_now == MODE_MONITOR) begin
                deg = temp_tenths / 10;
                cond = (deg >= high_lim) || (deg < low_lim);
                want.alarm_light = cond;
                want.buzzer_on   = cond & blink;
                over_flag        = (deg >= high_lim);
                under_flag       = (deg <= low_lim);
            end
            // over/under hold their monitor-mode values while editing
            want.over_led    = over_flag;
            want.under_led   = under_flag;
            want.mode        = mode_now;
            want.high_limit  = high_lim[LIMIT_W-1:0];
            want.low_limit   = low_lim[LIMIT_W-1:0];
            want.temp_tenths = temp_tenths[TEMP_W-1:0];
            status_q.push_back(want);
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_status(logic [31:0] word);
            t_status got;
            t_status want;
            got = word;
            if (status_q.size() == 0) begin
                report($sformatf("unexpected result 0x%08h", word));
            end else begin
                want = status_q.pop_front();
                compare_field("buzzer_on", 32'(got.buzzer_on), 32'(want.buzzer_on));
                compare_field("alarm_light", 32'(got.alarm_light), 32'(want.alarm_light));
                compare_field("over_led", 32'(got.over_led), 32'(want.over_led));
                compare_field("under_led", 32'(got.under_led), 32'(want.under_led));
                compare_field("edit_mode", 32'(got.mode), 32'(want.mode));
                compare_field("high_limit_out", 32'(got.high_limit), 32'(want.high_limit));
                compare_field("low_limit_out", 32'(got.low_limit), 32'(want.low_limit));
                compare_field("temp_tenths", 32'(got.temp_tenths), 32'(want.temp_tenths));
                compare_field("pad bit", 32'(got.pad), 32'(want.pad));
            end
        endtask
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata  = '0;   // [15:0] raw_reading
    logic [2:0]  i_s_tuser  = '0;   // [2:0] kind
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;         // [0] buzzer, [1] lamp, [2] over, [3] under,
                                    // [5:4] mode, [12:6] high, [19:13] low,
                                    // [30:20] temp_tenths, [31] zero

    alarm_scoreboard sb = new();
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int items_sent = 0;
    int cycles = 0;

    temperature_limit_alarm_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_status(o_m_tdata);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    function logic [15:0] pick_raw();
        // mostly around the limit range, sometimes the full 16 bits
        if ($urandom_range(99) < 70)
            return 16'($urandom_range(1999));
        return 16'($urandom);
    endfunction

    task send_event(input logic [2:0] kind, input logic [15:0] raw);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= raw;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_event(kind, raw);
        items_sent++;
    endtask

    task send_one_random();
        int pick;
        pick = $urandom_range(99);
        if (pick < 35)      send_event(KIND_TICK, pick_raw());
        else if (pick < 60) send_event(KIND_SAMPLE, pick_raw());
        else if (pick < 68) send_event(KIND_SET, pick_raw());
        else if (pick < 78) send_event(KIND_UP, pick_raw());
        else if (pick < 88) send_event(KIND_DOWN, pick_raw());
        else if (pick < 97) send_event(KIND_PAGE, pick_raw());
        else send_event($urandom_range(1) ? KIND_SPARE_6 : KIND_SPARE_7, pick_raw());
    endtask

    // enable keys, step to an edit page, push one limit hard, maybe return
    task run_edit_session();
        t_mode target;
        int    n;
        int    pick;
        bit    go_up;
        target = $urandom_range(1) ? MODE_EDIT_HI : MODE_EDIT_LO;
        if (!sb.keys_on) send_event(KIND_PAGE, pick_raw());
        while (sb.mode_now != target) send_event(KIND_SET, pick_raw());
        n = $urandom_range(70, 1);
        go_up = 1'($urandom_range(1));
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 8)       send_event(KIND_SAMPLE, pick_raw());
            else if (pick < 16) send_event(KIND_TICK, pick_raw());
            else if ($urandom_range(99) < 85)
                send_event(go_up ? KIND_UP : KIND_DOWN, pick_raw());
            else
                send_event(go_up ? KIND_DOWN : KIND_UP, pick_raw());
        end
        if ($urandom_range(3) != 0)
            while (sb.mode_now != MODE_MONITOR) send_event(KIND_SET, pick_raw());
    endtask

    task run_monitor_burst();
        int n;
        n = $urandom_range(30, 5);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(1)) send_event(KIND_TICK, pick_raw());
            else send_event(KIND_SAMPLE, pick_raw());
        end
    endtask

    initial begin
        int target;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: conversion extremes and rounding at the thresholds
        send_event(KIND_SAMPLE, 16'h0000);
        send_event(KIND_SAMPLE, 16'hFFFF);
        send_event(KIND_SAMPLE, 16'd1920);
        send_event(KIND_SAMPLE, 16'd1919);
        send_event(KIND_SAMPLE, 16'd640);
        send_event(KIND_SAMPLE, 16'd160);
        // keys ignored until the page toggle
        send_event(KIND_SET, 16'd0);
        send_event(KIND_UP, 16'd0);
        send_event(KIND_PAGE, 16'd0);
        send_event(KIND_UP, 16'd0);
        send_event(KIND_DOWN, 16'd0);
        send_event(KIND_SET, 16'd0);
        send_event(KIND_UP, 16'hFFFF);
        send_event(KIND_DOWN, 16'd0);
        send_event(KIND_SAMPLE, 16'd639);
        send_event(KIND_SET, 16'd0);
        send_event(KIND_UP, 16'd0);
        send_event(KIND_DOWN, 16'd0);
        send_event(KIND_SET, 16'd0);
        send_event(KIND_SPARE_6, 16'hA5A5);
        send_event(KIND_SPARE_7, 16'h5A5A);
        send_event(KIND_PAGE, 16'd0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 59; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 59; end
                default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
            endcase
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                case ($urandom_range(99) / 20)
                    0, 1:    run_edit_session();
                    2:       run_monitor_burst();
                    default: send_one_random();
                endcase
            end
        end

        i_s_tvalid <= 1'b0;
        tx_idle_pct = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
